// ===== rtl/i2cmb_pkg.sv =====
package i2cmb_pkg;

   // Field widths fixed by the command format
   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned HALF_W      = 16;
   localparam int unsigned BITS_W      = 4;

   // Defaults and constants
   localparam int unsigned WAIT_WIDTH_DEF = 16;
   localparam int unsigned QUEUE_DEPTH    = 2;
   localparam logic [HALF_W-1:0] HALF_RESET = 16'd500;
   localparam logic [BITS_W-1:0] BYTE_BITS  = 4'd8;

   // Command opcodes on the request channel
   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_STOP  = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;
   localparam logic [1:0] OP_READ  = 2'd3;

   // Classified command carried from front to back
   typedef enum logic [2:0] {
      KIND_NONE  = 3'd0,
      KIND_START = 3'd1,
      KIND_STOP  = 3'd2,
      KIND_WRITE = 3'd3,
      KIND_READ  = 3'd4
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic [BYTE_W-1:0] write_data;
      logic              send_ack;
      logic              sda_in;
   } item_type;

   // Queue occupancy seen by the front end and the top level
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ===== rtl/i2cmb_ifs.sv =====
// Request channel: one tick per beat
interface i2cmb_req_if;
   logic       valid;
   logic       ready;
   logic       cmd_valid;
   logic [1:0] op;
   logic [7:0] write_data;
   logic       send_ack;
   logic       sda_in;

   modport source (output valid, cmd_valid, op, write_data, send_ack, sda_in, input ready);
   modport sink   (input valid, cmd_valid, op, write_data, send_ack, sda_in, output ready);
endinterface

// Response channel: pin drives and status per tick
interface i2cmb_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_pull_low;
   logic       sda_pull_low;
   logic       busy_res;
   logic       done_res;
   logic [7:0] read_data;
   logic       ack_received;

   modport source (output valid, scl_pull_low, sda_pull_low, busy_res, done_res,
                   read_data, ack_received, input ready);
   modport sink   (input valid, scl_pull_low, sda_pull_low, busy_res, done_res,
                   read_data, ack_received, output ready);
endinterface

// Register write channel: half period only
interface i2cmb_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/i2cmb_front.sv =====
module i2cmb_front (
   i2cmb_req_if.sink            req_chan,
   input  i2cmb_pkg::queue_status_type q_status,
   output logic                 push,
   output i2cmb_pkg::item_type  push_item
);
   import i2cmb_pkg::*;

   // Take a beat whenever the queue has room
   assign req_chan.ready = !q_status.full;
   assign push           = req_chan.valid && !q_status.full;

   // Classify the tick into a command kind
   always_comb begin
      push_item.write_data = req_chan.write_data;
      push_item.send_ack   = req_chan.send_ack;
      push_item.sda_in     = req_chan.sda_in;
      push_item.kind       = KIND_NONE;
      if (req_chan.cmd_valid) begin
         unique case (req_chan.op)
            OP_START: push_item.kind = KIND_START;
            OP_STOP:  push_item.kind = KIND_STOP;
            OP_WRITE: push_item.kind = KIND_WRITE;
            OP_READ:  push_item.kind = KIND_READ;
            default:  push_item.kind = KIND_NONE;
         endcase
      end
   end

endmodule

// ===== rtl/i2cmb_queue.sv =====
module i2cmb_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  i2cmb_pkg::item_type          push_item,
   input  logic                         pop,
   output i2cmb_pkg::item_type          pop_item,
   output i2cmb_pkg::queue_status_type  status
);
   import i2cmb_pkg::*;

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type             entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   assign status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_item     = entry_ff[rd_ptr_ff];

   // Pointer wrap and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== rtl/i2cmb_back.sv =====
module i2cmb_back #(
   parameter int unsigned WAIT_WIDTH = i2cmb_pkg::WAIT_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [i2cmb_pkg::HALF_W-1:0]      half_period,
   input  logic                              q_empty,
   input  i2cmb_pkg::item_type               item,
   output logic                              pop,
   i2cmb_rsp_if.source                       rsp_chan
);
   import i2cmb_pkg::*;

   typedef enum logic [11:0] {
      PH_IDLE        = 12'b0000_0000_0001,
      PH_START_A     = 12'b0000_0000_0010,
      PH_START_B     = 12'b0000_0000_0100,
      PH_STOP_A      = 12'b0000_0000_1000,
      PH_WR_DATA     = 12'b0000_0001_0000,
      PH_WR_HIGH     = 12'b0000_0010_0000,
      PH_WR_ACK_LOW  = 12'b0000_0100_0000,
      PH_WR_ACK_HIGH = 12'b0000_1000_0000,
      PH_RD_HIGH     = 12'b0001_0000_0000,
      PH_RD_LOW      = 12'b0010_0000_0000,
      PH_RD_ACK_LOW  = 12'b0100_0000_0000,
      PH_RD_ACK_HIGH = 12'b1000_0000_0000
   } phase_type;

   phase_type               phase_ff, phase_in;
   logic [BITS_W-1:0]       bits_ff, bits_in;
   logic [BYTE_W-1:0]       shift_ff, shift_in;
   logic [WAIT_WIDTH-1:0]   wait_ff, wait_in;
   logic                    scl_ff, scl_in;
   logic                    sda_ff, sda_in_nx;
   logic                    ack_seen_ff, ack_seen_in;
   logic                    ack_send_ff, ack_send_in;
   logic [BYTE_W-1:0]       read_hold_ff, read_hold_in;
   logic                    done;
   logic                    rsp_valid_ff;

   logic [WAIT_WIDTH-1:0]   half_w;
   logic [WAIT_WIDTH-1:0]   wait_len;
   logic [WAIT_WIDTH-1:0]   wait_dec;
   logic [BYTE_W-1:0]       shift_up;
   logic [BITS_W-1:0]       bits_dec;

   // Half-bit wait length, a zero setting counts as one tick
   assign half_w   = WAIT_WIDTH'(half_period);
   assign wait_len = (half_w == '0) ? WAIT_WIDTH'(1) : half_w;
   assign wait_dec = (wait_ff != '0) ? wait_ff - 1'b1 : wait_ff;
   assign bits_dec = (bits_ff != '0) ? bits_ff - 1'b1 : bits_ff;
   assign shift_up = {shift_ff[BYTE_W-2:0], 1'b0};

   // Consume one tick whenever the output slot is free or being drained
   assign pop = !q_empty && (!rsp_valid_ff || rsp_chan.ready);

   // Bit engine: one tick per beat
   always_comb begin
      phase_in     = phase_ff;
      bits_in      = bits_ff;
      shift_in     = shift_ff;
      wait_in      = wait_ff;
      scl_in       = scl_ff;
      sda_in_nx    = sda_ff;
      ack_seen_in  = ack_seen_ff;
      ack_send_in  = ack_send_ff;
      read_hold_in = read_hold_ff;
      done         = 1'b0;
      if (phase_ff == PH_IDLE) begin
         case (item.kind)
            KIND_START: begin
               sda_in_nx = 1'b0;
               scl_in    = 1'b0;
               phase_in  = PH_START_A;
               wait_in   = wait_len;
            end
            KIND_STOP: begin
               sda_in_nx = 1'b1;
               scl_in    = 1'b0;
               phase_in  = PH_STOP_A;
               wait_in   = wait_len;
            end
            KIND_WRITE: begin
               shift_in  = item.write_data;
               bits_in   = BYTE_BITS;
               sda_in_nx = ~item.write_data[BYTE_W-1];
               phase_in  = PH_WR_DATA;
               wait_in   = wait_len;
            end
            KIND_READ: begin
               shift_in    = '0;
               bits_in     = BYTE_BITS;
               ack_send_in = item.send_ack;
               sda_in_nx   = 1'b0;
               scl_in      = 1'b0;
               phase_in    = PH_RD_HIGH;
               wait_in     = wait_len;
            end
            default: ;
         endcase
      end else begin
         wait_in = wait_dec;
         if (wait_dec == '0) begin
            unique case (phase_ff)
               PH_START_A: begin
                  sda_in_nx = 1'b1;
                  phase_in  = PH_START_B;
                  wait_in   = wait_len;
               end
               PH_START_B: begin
                  scl_in   = 1'b1;
                  phase_in = PH_IDLE;
                  done     = 1'b1;
               end
               PH_STOP_A: begin
                  sda_in_nx = 1'b0;
                  phase_in  = PH_IDLE;
                  done      = 1'b1;
               end
               PH_WR_DATA: begin
                  scl_in   = 1'b0;
                  phase_in = PH_WR_HIGH;
                  wait_in  = wait_len;
               end
               PH_WR_HIGH: begin
                  // SCL low again, next data bit on the same tick
                  scl_in   = 1'b1;
                  shift_in = shift_up;
                  bits_in  = bits_dec;
                  wait_in  = wait_len;
                  if (bits_dec != '0) begin
                     sda_in_nx = ~shift_up[BYTE_W-1];
                     phase_in  = PH_WR_DATA;
                  end else begin
                     sda_in_nx = 1'b0;
                     phase_in  = PH_WR_ACK_LOW;
                  end
               end
               PH_WR_ACK_LOW: begin
                  scl_in   = 1'b0;
                  phase_in = PH_WR_ACK_HIGH;
                  wait_in  = wait_len;
               end
               PH_WR_ACK_HIGH: begin
                  ack_seen_in = ~item.sda_in;
                  scl_in      = 1'b1;
                  phase_in    = PH_IDLE;
                  done        = 1'b1;
               end
               PH_RD_HIGH: begin
                  shift_in = {shift_ff[BYTE_W-2:0], item.sda_in};
                  bits_in  = bits_dec;
                  scl_in   = 1'b1;
                  phase_in = PH_RD_LOW;
                  wait_in  = wait_len;
               end
               PH_RD_LOW: begin
                  wait_in = wait_len;
                  if (bits_ff != '0) begin
                     scl_in   = 1'b0;
                     phase_in = PH_RD_HIGH;
                  end else begin
                     sda_in_nx = ack_send_ff;
                     phase_in  = PH_RD_ACK_LOW;
                  end
               end
               PH_RD_ACK_LOW: begin
                  scl_in   = 1'b0;
                  phase_in = PH_RD_ACK_HIGH;
                  wait_in  = wait_len;
               end
               PH_RD_ACK_HIGH: begin
                  scl_in       = 1'b1;
                  sda_in_nx    = 1'b0;
                  read_hold_in = shift_ff;
                  phase_in     = PH_IDLE;
                  done         = 1'b1;
               end
               default: phase_in = PH_IDLE;
            endcase
         end
      end
   end

   // Engine state advances once per consumed tick
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         bits_ff      <= '0;
         shift_ff     <= '0;
         wait_ff      <= '0;
         scl_ff       <= 1'b0;
         sda_ff       <= 1'b0;
         ack_seen_ff  <= 1'b0;
         ack_send_ff  <= 1'b0;
         read_hold_ff <= '0;
      end else if (pop) begin
         phase_ff     <= phase_in;
         bits_ff      <= bits_in;
         shift_ff     <= shift_in;
         wait_ff      <= wait_in;
         scl_ff       <= scl_in;
         sda_ff       <= sda_in_nx;
         ack_seen_ff  <= ack_seen_in;
         ack_send_ff  <= ack_send_in;
         read_hold_ff <= read_hold_in;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_chan.scl_pull_low <= scl_in;
         rsp_chan.sda_pull_low <= sda_in_nx;
         rsp_chan.busy_res     <= (phase_in != PH_IDLE);
         rsp_chan.done_res     <= done;
         rsp_chan.read_data    <= read_hold_in;
         rsp_chan.ack_received <= ack_seen_in;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;

endmodule

// ===== rtl/i2c_master_bit_engine.sv =====
// I2C master bit engine, open drain, advanced one tick per request beat.
// req_chan: one beat per timer tick with the sampled SDA level and, when
//   cmd_valid is set, a start, stop, write-byte or read-byte command.
//   Commands that arrive while a command is running are dropped.
// rsp_chan: exactly one beat per request beat, in order, carrying the SCL
//   and SDA pull-low drives, busy, a done pulse, the last read byte and the
//   ack seen on the last write.
// csr_chan: writes the half-bit period in ticks (reset 500); write only
//   while no beat is in flight. Always ready.
// Path: a taken request beat is written into a queue entry, then the
//   engine step registers its response beat into the output register.
// Throughput: one beat per cycle while the response side takes beats.
// Reset: lines released, engine idle, queue empty, period back to default.
// Receiver stall: the output register holds its beat, the two-entry queue
//   absorbs up to two more ticks, then req_chan.ready drops until the
//   response side drains.
module i2c_master_bit_engine #(
   parameter int unsigned WAIT_WIDTH = i2cmb_pkg::WAIT_WIDTH_DEF
) (
   input  logic          clock,
   input  logic          reset,
   i2cmb_req_if.sink     req_chan,
   i2cmb_rsp_if.source   rsp_chan,
   i2cmb_csr_if.sink     csr_chan
);
   import i2cmb_pkg::*;

   logic [HALF_W-1:0]  half_ff;
   logic               push;
   logic               pop;
   item_type           push_item;
   item_type           pop_item;
   queue_status_type   q_status;

   // Half-period register
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff <= HALF_RESET;
      end else if (csr_chan.valid) begin
         half_ff <= csr_chan.data;
      end
   end

   i2cmb_front u_front (
      .req_chan  (req_chan),
      .q_status  (q_status),
      .push      (push),
      .push_item (push_item)
   );

   i2cmb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .status    (q_status)
   );

   i2cmb_back #(
      .WAIT_WIDTH (WAIT_WIDTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .half_period (half_ff),
      .q_empty     (q_status.empty),
      .item        (pop_item),
      .pop         (pop),
      .rsp_chan    (rsp_chan)
   );

   // A fresh response beat needs a queued tick behind it
   a_rsp_from_queue: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(!q_status.empty))
      else $error("response beat without a queued tick");

   // A full queue must refuse requests
   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      q_status.full |-> !req_chan.ready)
      else $error("request taken into a full queue");

   // Queue cannot be full and empty at once
   a_queue_sane: assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("queue reports full and empty");

   // An engine step always leaves a beat in the output register
   a_step_lands: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_chan.valid)
      else $error("engine step lost its response beat");

endmodule

// ===== verif/i2cmb_waveform_checker.sv =====
`timescale 1ns / 1ps

// Watches the request, response and register channels, predicts the pin
// drives and status of every tick and compares them with the response beats.
module i2cmb_waveform_checker (
   input  logic  clock,
   input  logic  reset,
   i2cmb_req_if  req_mon,
   i2cmb_rsp_if  rsp_mon,
   i2cmb_csr_if  csr_mon,
   output int    fail_count,
   output int    pending,
   output logic  engine_idle
);
   import i2cmb_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_START_HOLD,
      S_START_LOW,
      S_STOP_HOLD,
      S_WR_BIT,
      S_WR_CLK,
      S_WR_ACK_REL,
      S_WR_ACK_CLK,
      S_RD_CLK,
      S_RD_LOW,
      S_RD_ACK_SET,
      S_RD_ACK_CLK
   } step_type;

   typedef struct packed {
      logic       scl;
      logic       sda;
      logic       busy;
      logic       done;
      logic [7:0] rdata;
      logic       ack;
   } tick_status_type;

   // engine copy
   logic [HALF_W-1:0] half_ticks = HALF_RESET;
   step_type          st         = S_IDLE;
   logic [BITS_W-1:0] bits_left  = '0;
   logic [7:0]        shreg      = '0;
   logic [15:0]       wait_cnt   = '0;
   logic              scl_d      = 1'b0;
   logic              sda_d      = 1'b0;
   logic              ack_seen   = 1'b0;
   logic              ack_tx     = 1'b0;
   logic [7:0]        rd_hold    = '0;

   tick_status_type expected_lines[$];
   int              n_fail    = 0;
   int              n_pending = 0;

   assign fail_count  = n_fail;
   assign pending     = n_pending;
   assign engine_idle = (st == S_IDLE);

   // a zero period counts as a single tick
   task automatic enter_wait(input step_type nxt);
      st       = nxt;
      wait_cnt = (half_ticks == '0) ? 16'd1 : half_ticks;
   endtask

   function automatic string show(input tick_status_type s);
      return $sformatf("scl=%b sda=%b busy=%b done=%b rd=%h ack=%b",
                       s.scl, s.sda, s.busy, s.done, s.rdata, s.ack);
   endfunction

   // one timer tick of the engine
   task automatic step_engine(input logic cmdv, input logic [1:0] opc,
                              input logic [7:0] wd, input logic sack,
                              input logic sda_in, output tick_status_type res);
      logic done_now;
      done_now = 1'b0;
      if (st == S_IDLE) begin
         if (cmdv) begin
            case (opc)
               OP_START: begin
                  sda_d = 1'b0;
                  scl_d = 1'b0;
                  enter_wait(S_START_HOLD);
               end
               OP_STOP: begin
                  sda_d = 1'b1;
                  scl_d = 1'b0;
                  enter_wait(S_STOP_HOLD);
               end
               OP_WRITE: begin
                  shreg     = wd;
                  bits_left = BYTE_BITS;
                  sda_d     = ~wd[7];
                  enter_wait(S_WR_BIT);
               end
               default: begin
                  shreg     = '0;
                  bits_left = BYTE_BITS;
                  ack_tx    = sack;
                  sda_d     = 1'b0;
                  scl_d     = 1'b0;
                  enter_wait(S_RD_CLK);
               end
            endcase
         end
      end else begin
         if (wait_cnt != '0) wait_cnt = wait_cnt - 16'd1;
         if (wait_cnt == '0) begin
            case (st)
               S_START_HOLD: begin
                  sda_d = 1'b1;
                  enter_wait(S_START_LOW);
               end
               S_START_LOW: begin
                  scl_d    = 1'b1;
                  st       = S_IDLE;
                  done_now = 1'b1;
               end
               S_STOP_HOLD: begin
                  sda_d    = 1'b0;
                  st       = S_IDLE;
                  done_now = 1'b1;
               end
               S_WR_BIT: begin
                  scl_d = 1'b0;
                  enter_wait(S_WR_CLK);
               end
               S_WR_CLK: begin
                  // clock low again, next bit goes out on the same tick
                  scl_d = 1'b1;
                  shreg = shreg << 1;
                  if (bits_left != '0) bits_left = bits_left - 1'b1;
                  if (bits_left != '0) begin
                     sda_d = ~shreg[7];
                     enter_wait(S_WR_BIT);
                  end else begin
                     sda_d = 1'b0;
                     enter_wait(S_WR_ACK_REL);
                  end
               end
               S_WR_ACK_REL: begin
                  scl_d = 1'b0;
                  enter_wait(S_WR_ACK_CLK);
               end
               S_WR_ACK_CLK: begin
                  // ack sampled while SCL is still high
                  ack_seen = ~sda_in;
                  scl_d    = 1'b1;
                  st       = S_IDLE;
                  done_now = 1'b1;
               end
               S_RD_CLK: begin
                  shreg = {shreg[6:0], sda_in};
                  if (bits_left != '0) bits_left = bits_left - 1'b1;
                  scl_d = 1'b1;
                  enter_wait(S_RD_LOW);
               end
               S_RD_LOW: begin
                  if (bits_left != '0) begin
                     scl_d = 1'b0;
                     enter_wait(S_RD_CLK);
                  end else begin
                     sda_d = ack_tx;
                     enter_wait(S_RD_ACK_SET);
                  end
               end
               S_RD_ACK_SET: begin
                  scl_d = 1'b0;
                  enter_wait(S_RD_ACK_CLK);
               end
               S_RD_ACK_CLK: begin
                  scl_d    = 1'b1;
                  sda_d    = 1'b0;
                  rd_hold  = shreg;
                  st       = S_IDLE;
                  done_now = 1'b1;
               end
               default: st = S_IDLE;
            endcase
         end
      end
      res.scl   = scl_d;
      res.sda   = sda_d;
      res.busy  = (st != S_IDLE);
      res.done  = done_now;
      res.rdata = rd_hold;
      res.ack   = ack_seen;
   endtask

   // register writes, response compare, then prediction of the new beat
   always @(posedge clock) begin : watch
      tick_status_type got;
      tick_status_type want;
      if (reset) begin
         half_ticks = HALF_RESET;
         st         = S_IDLE;
         bits_left  = '0;
         shreg      = '0;
         wait_cnt   = '0;
         scl_d      = 1'b0;
         sda_d      = 1'b0;
         ack_seen   = 1'b0;
         ack_tx     = 1'b0;
         rd_hold    = '0;
         expected_lines.delete();
         n_pending  = 0;
      end else begin
         if (csr_mon.valid && csr_mon.ready) half_ticks = csr_mon.data;

         if (rsp_mon.valid && rsp_mon.ready) begin
            got.scl   = rsp_mon.scl_pull_low;
            got.sda   = rsp_mon.sda_pull_low;
            got.busy  = rsp_mon.busy_res;
            got.done  = rsp_mon.done_res;
            got.rdata = rsp_mon.read_data;
            got.ack   = rsp_mon.ack_received;
            if (expected_lines.size() == 0) begin
               n_fail++;
               if (n_fail <= 10)
                  $display("%0t: response beat with none expected: %s", $time, show(got));
            end else begin
               want = expected_lines.pop_front();
               if (got.scl !== want.scl || got.sda !== want.sda ||
                   got.busy !== want.busy || got.done !== want.done ||
                   got.rdata !== want.rdata || got.ack !== want.ack) begin
                  n_fail++;
                  if (n_fail <= 10)
                     $display("%0t: response mismatch: expected %s, got %s",
                              $time, show(want), show(got));
               end
            end
         end

         if (req_mon.valid && req_mon.ready) begin
            step_engine(req_mon.cmd_valid, req_mon.op, req_mon.write_data,
                        req_mon.send_ack, req_mon.sda_in, want);
            expected_lines.push_back(want);
         end
         n_pending = expected_lines.size();
      end
   end

endmodule

// ===== verif/tb_i2c_master_bit_engine.sv =====
`timescale 1ns / 1ps

module tb_i2c_master_bit_engine;
   import i2cmb_pkg::*;

   typedef struct packed {
      logic [1:0] opc;
      logic [7:0] data;
      logic       ack;
   } bus_cmd_type;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending;
   logic engine_idle;
   int   burst_left = 0;
   int   stall_left = 0;
   int   run_left   = 0;

   i2cmb_req_if req_bus ();
   i2cmb_rsp_if rsp_bus ();
   i2cmb_csr_if csr_bus ();

   i2c_master_bit_engine u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   i2cmb_waveform_checker u_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .csr_mon     (csr_bus),
      .fail_count  (fail_count),
      .pending     (pending),
      .engine_idle (engine_idle)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // response side: short stalls between runs, now and then a long clean run
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_bus.ready <= 1'b1;
         if (run_left > 0) begin
            run_left--;
         end else begin
            run_left   = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(0, 20);
            stall_left = $urandom_range(1, 5);
         end
      end
   end

   function automatic bus_cmd_type rand_cmd();
      bus_cmd_type c;
      c.opc  = 2'($urandom_range(0, 3));
      c.data = 8'($urandom_range(0, 255));
      c.ack  = 1'($urandom_range(0, 1));
      return c;
   endfunction

   // Tasks start and end at a falling edge on which nothing has been driven yet.

   // end of a burst: a random gap with valid low, then a new burst length
   task automatic next_slot();
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 6);
         repeat (gap) begin
            req_bus.valid <= 1'b0;
            @(negedge clock);
         end
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 24);
      end
      burst_left--;
   endtask

   // one tick beat, held until taken
   task automatic put_tick(input logic cmdv, input bus_cmd_type c);
      req_bus.valid      <= 1'b1;
      req_bus.cmd_valid  <= cmdv;
      req_bus.op         <= c.opc;
      req_bus.write_data <= c.data;
      req_bus.send_ack   <= c.ack;
      req_bus.sda_in     <= 1'($urandom_range(0, 1));
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // issue one command on an idle engine and tick until it has finished
   task automatic run_cmd(input logic [1:0] opc, input logic [7:0] data,
                          input logic ack, input bit noisy);
      bus_cmd_type c;
      bit          issued;
      c      = rand_cmd();
      c.opc  = opc;
      c.data = data;
      c.ack  = ack;
      issued = 1'b0;
      next_slot();
      while (!(issued && engine_idle)) begin
         if (!issued) begin
            put_tick(1'b1, c);
            issued = 1'b1;
         end else if (noisy && $urandom_range(0, 2) == 0) begin
            put_tick(1'b1, rand_cmd());
         end else begin
            put_tick(1'b0, rand_cmd());
         end
         next_slot();
      end
   endtask

   // mostly whole transfers with random content, some broken command runs
   task automatic random_phase(input int n_ticks);
      bus_cmd_type plan[$];
      bus_cmd_type c;
      int          n;
      bit          rd;
      for (int k = 0; k < n_ticks; k++) begin
         next_slot();
         if (engine_idle) begin
            if (plan.size() == 0) begin
               if ($urandom_range(0, 5) == 0) begin
                  n = $urandom_range(1, 4);
                  repeat (n) plan.push_back(rand_cmd());
               end else begin
                  c = rand_cmd();
                  c.opc = OP_START;
                  plan.push_back(c);
                  c = rand_cmd();
                  c.opc = OP_WRITE;
                  plan.push_back(c);
                  n  = $urandom_range(1, 3);
                  rd = 1'($urandom_range(0, 1));
                  for (int j = 0; j < n; j++) begin
                     c = rand_cmd();
                     c.opc = rd ? OP_READ : OP_WRITE;
                     c.ack = (j != n - 1);
                     plan.push_back(c);
                  end
                  c = rand_cmd();
                  c.opc = OP_STOP;
                  plan.push_back(c);
               end
            end
            if ($urandom_range(0, 3) != 0) put_tick(1'b1, plan.pop_front());
            else                           put_tick(1'b0, rand_cmd());
         end else if ($urandom_range(0, 11) == 0) begin
            put_tick(1'b1, rand_cmd());
         end else begin
            put_tick(1'b0, rand_cmd());
         end
      end
      // let the running command finish
      next_slot();
      while (!engine_idle) begin
         put_tick(1'b0, rand_cmd());
         next_slot();
      end
   endtask

   // sender stops until every beat in flight has come back
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
   endtask

   task automatic write_half(input logic [15:0] ticks);
      drain();
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= ticks;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   initial begin
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.cmd_valid  = 1'b0;
      req_bus.op         = OP_START;
      req_bus.write_data = '0;
      req_bus.send_ack   = 1'b0;
      req_bus.sda_in     = 1'b1;
      rsp_bus.ready      = 1'b0;
      csr_bus.valid      = 1'b0;
      csr_bus.data       = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // default period straight out of reset
      run_cmd(OP_STOP, 8'h00, 1'b0, 1'b0);

      // directed: quiet ticks, byte extremes, both read acks, busy drops
      write_half(16'd1);
      repeat (3) begin
         next_slot();
         put_tick(1'b0, rand_cmd());
      end
      run_cmd(OP_START, 8'h00, 1'b0, 1'b0);
      run_cmd(OP_WRITE, 8'h00, 1'b0, 1'b0);
      run_cmd(OP_WRITE, 8'hFF, 1'b1, 1'b1);
      run_cmd(OP_WRITE, 8'hA5, 1'b0, 1'b0);
      run_cmd(OP_READ,  8'h00, 1'b1, 1'b0);
      run_cmd(OP_READ,  8'hFF, 1'b0, 1'b1);
      run_cmd(OP_STOP,  8'h00, 1'b0, 1'b0);
      run_cmd(OP_STOP,  8'h00, 1'b0, 1'b0);
      run_cmd(OP_START, 8'h00, 1'b0, 1'b0);
      run_cmd(OP_START, 8'h00, 1'b0, 1'b1);
      run_cmd(OP_READ,  8'h00, 1'b1, 1'b1);
      run_cmd(OP_WRITE, 8'h5A, 1'b1, 1'b0);
      run_cmd(OP_STOP,  8'h00, 1'b0, 1'b1);

      // random traffic over several periods, a longer period on a single stop
      write_half(16'd2);
      random_phase(250);
      write_half(16'd1);
      random_phase(250);
      write_half(16'd37);
      run_cmd(OP_STOP, 8'h00, 1'b0, 1'b1);
      write_half(16'd0);
      random_phase(200);
      write_half(16'd3);
      random_phase(150);
      write_half(16'd4);
      random_phase(150);

      drain();
      repeat (10) @(negedge clock);
      if (fail_count == 0 && pending == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #80_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
